>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by ssnf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SSNF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define SSNF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ssnf_pkg.sv
// Package for the seven-segment number formatter: widths, codes, segment table.
// No dependencies; used by the interfaces, the top level and the checker.
package ssnf_pkg;

  localparam int NUM_DIGITS_DEF = 8;
  localparam int ADDR_W         = 4;
  localparam int SEG_W          = 8;
  localparam int VAL_W          = 32;
  // Double-dabble shift steps done in each pipeline stage
  localparam int DD_STEPS       = 4;

  // Number format codes
  typedef enum logic [0:0] {
    OP_INT   = 1'b0,
    OP_FIXED = 1'b1
  } op_t;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h01;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;
  localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

  // 10^n for small n, elaboration use only
  function automatic logic [VAL_W-1:0] pow10(input int n);
    logic [VAL_W-1:0] r;
    r = VAL_W'(1);
    for (int i = 0; i < n; i++) begin
      r = VAL_W'(r * VAL_W'(10));
    end
    return r;
  endfunction

  // BCD digit to segments a..g
  function automatic logic [SEG_W-1:0] digit_seg(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0: s = 8'h7E;
      4'd1: s = 8'h30;
      4'd2: s = 8'h6D;
      4'd3: s = 8'h79;
      4'd4: s = 8'h33;
      4'd5: s = 8'h5B;
      4'd6: s = 8'h5F;
      4'd7: s = 8'h70;
      4'd8: s = 8'h7F;
      4'd9: s = 8'h7B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

>>> src/ssnf_if.sv
// Valid/ready channel interfaces: number items in, display-register write items out.
// Depends on ssnf_pkg.
interface ssnf_num_if import ssnf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [VAL_W-1:0] signed_value;

  modport source (output valid, opcode, signed_value, input ready);
  modport sink   (input valid, opcode, signed_value, output ready);
endinterface

interface ssnf_wr_if import ssnf_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] reg_address;
  logic [SEG_W-1:0]  seg_data;
  logic              last_write;

  modport source (output valid, reg_address, seg_data, last_write, input ready);
  modport sink   (input valid, reg_address, seg_data, last_write, output ready);
endinterface

>>> src/seven_segment_number_formatter.sv
// Seven-segment number formatter top level: range check, pipelined BCD, segments, writer.
// Depends on ssnf_pkg and the interfaces in ssnf_if.sv.
//
//  channel   dir  handshake      payload
//  number    in   valid/ready    opcode, signed_value
//  display   out  valid/ready    reg_address, seg_data, last_write
//
// An accepted number goes through the input register, the dabble stages and the segment stage
// into the write frame, then its NUM_DIGITS writes follow back to back while display is ready.
// The single write port limits the rate of numbers; numbers queue in the pipeline
// meanwhile, one may enter every cycle it has room.
// Reset clears the stage valid bits and the writer; data registers are not reset.
// Stalls on display back up stage by stage; no item is dropped or repeated.
module seven_segment_number_formatter import ssnf_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ssnf_num_if.sink   number,
  ssnf_wr_if.source  display
);

  localparam logic [VAL_W-1:0] POS_LIM = pow10(NUM_DIGITS) - VAL_W'(1);
  localparam logic [VAL_W-1:0] NEG_LIM = pow10(NUM_DIGITS - 1) - VAL_W'(1);
  localparam int MAG_W = $clog2(pow10(NUM_DIGITS));
  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int NDD   = (MAG_W + DD_STEPS - 1) / DD_STEPS;
  localparam int NS    = NDD + 2;               // input, dabble stages, segment stage
  localparam int SH_W  = $clog2(NUM_DIGITS + 1);
  localparam int POS_W = $clog2(NUM_DIGITS);

  // DD_STEPS shift-and-adjust steps starting at step first, skipping any step at or past MAG_W
  function automatic logic [BCD_W+MAG_W-1:0] dd_stage(
    input logic [BCD_W-1:0] b_in,
    input logic [MAG_W-1:0] m_in,
    input int               first
  );
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] m;
    b = b_in;
    m = m_in;
    for (int j = 0; j < DD_STEPS; j++) begin
      if (first + j < MAG_W) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          if (b[4*d +: 4] >= 4'd5) b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
        {b, m} = {b, m} << 1;
      end
    end
    return {b, m};
  endfunction

  // Stage control
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;
  logic          frame_ready;

  // Stage data: index 0 is the input register, 1..NDD the dabble stages
  logic [BCD_W-1:0] bcd   [0:NDD];
  logic [MAG_W-1:0] bin   [0:NDD];
  logic             fixed [0:NDD];
  logic             neg   [0:NDD];
  logic             ovf   [0:NDD];
  logic [BCD_W-1:0] bcd_next [1:NDD];
  logic [MAG_W-1:0] bin_next [1:NDD];

  // Segment stage and write frame
  logic [SEG_W-1:0] seg       [NUM_DIGITS];
  logic [SEG_W-1:0] seg_next  [NUM_DIGITS];
  logic [SEG_W-1:0] frame     [NUM_DIGITS];
  logic [POS_W-1:0] pos;
  logic             busy;

  // Input magnitude and range check
  logic             in_neg;
  logic [VAL_W-1:0] in_mag;
  logic             in_ovf;

  always_comb begin
    in_neg = number.signed_value[VAL_W-1];
    in_mag = in_neg ? VAL_W'(-number.signed_value) : VAL_W'(number.signed_value);
    in_ovf = in_neg ? (in_mag > NEG_LIM) : (in_mag > POS_LIM);
  end

  // Ready chain, back from the writer
  always_comb begin
    frame_ready = !busy || (display.ready && pos == '0);
    rdy[NS-1]   = !vld[NS-1] || frame_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign number.ready = rdy[0];

  // Dabble stages
  always_comb begin
    for (int s = 1; s <= NDD; s++) begin
      {bcd_next[s], bin_next[s]} = dd_stage(bcd[s-1], bin[s-1], (s - 1) * DD_STEPS);
    end
  end

  // Blanking, sign, point and dashes from the finished BCD
  logic [SH_W-1:0] shown;
  logic [SH_W-1:0] min_shown;
  logic [3:0]      dig;

  always_comb begin
    shown     = '0;
    min_shown = fixed[NDD] ? SH_W'(4) : SH_W'(1);
    dig       = '0;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      if (bcd[NDD][4*p +: 4] != 4'd0) shown = SH_W'(p + 1);
    end
    if (shown < min_shown) shown = min_shown;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      dig = bcd[NDD][4*p +: 4];
      if (ovf[NDD]) begin
        seg_next[p] = SEG_MINUS;
      end else if (SH_W'(p) < shown) begin
        seg_next[p] = digit_seg(dig);
        if (fixed[NDD] && p == 3) seg_next[p] = seg_next[p] | SEG_POINT;
      end else if (SH_W'(p) == shown && neg[NDD]) begin
        seg_next[p] = SEG_MINUS;
      end else begin
        seg_next[p] = SEG_BLANK;
      end
    end
  end

  // Valid bits and writer control
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (rdy[0]) vld[0] <= number.valid;
      for (int s = 1; s < NS; s++) begin
        if (rdy[s]) vld[s] <= vld[s-1];
      end
      if (frame_ready && vld[NS-1]) begin
        busy <= 1'b1;
        pos  <= POS_W'(NUM_DIGITS - 1);
      end else if (busy && display.ready) begin
        if (pos == '0) busy <= 1'b0;
        else pos <= pos - POS_W'(1);
      end
    end
  end

  // Stage data, no reset
  always_ff @(posedge clk) begin
    if (rdy[0] && number.valid) begin
      bcd[0]   <= '0;
      bin[0]   <= MAG_W'(in_mag);
      fixed[0] <= (number.opcode == OP_FIXED);
      neg[0]   <= in_neg;
      ovf[0]   <= in_ovf;
    end
    for (int s = 1; s <= NDD; s++) begin
      if (rdy[s] && vld[s-1]) begin
        bcd[s]   <= bcd_next[s];
        bin[s]   <= bin_next[s];
        fixed[s] <= fixed[s-1];
        neg[s]   <= neg[s-1];
        ovf[s]   <= ovf[s-1];
      end
    end
    if (rdy[NS-1] && vld[NS-2]) seg <= seg_next;
    if (frame_ready && vld[NS-1]) frame <= seg;
  end

  // Write item out of the frame
  assign display.valid       = busy;
  assign display.reg_address = ADDR_W'(pos) + ADDR_W'(1);
  assign display.seg_data    = frame[pos];
  assign display.last_write  = (pos == '0);

endmodule

>>> src/ssnf_checker.sv
// Port-level checks on the display write channel of the formatter.
// Depends on ssnf_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module ssnf_checker import ssnf_pkg::*; #(
  parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              wr_valid,
  input logic              wr_ready,
  input logic [ADDR_W-1:0] wr_reg_address,
  input logic [SEG_W-1:0]  wr_seg_data,
  input logic              wr_last_write
);

  // Last write flag marks register 1 and nothing else
  `SSNF_ASSERT_IMP(a_last_on_reg1, clk, rst, wr_valid, wr_last_write == (wr_reg_address == ADDR_W'(1)), "last_write does not match register 1")

  // Within a frame the writes follow back to back, one register lower each time
  `SSNF_ASSERT_NXT(a_addr_steps_down, clk, rst, wr_valid && wr_ready && !wr_last_write, wr_valid && wr_reg_address == $past(wr_reg_address) - ADDR_W'(1), "frame writes not consecutive")

  // A new frame starts at the leftmost register
  `SSNF_ASSERT_NXT(a_frame_start, clk, rst, wr_valid && wr_ready && wr_last_write, !wr_valid || wr_reg_address == ADDR_W'(NUM_DIGITS), "frame does not start at leftmost register")

  // A stalled write item holds
  `SSNF_ASSERT_NXT(a_stall_hold, clk, rst, wr_valid && !wr_ready, wr_valid && $stable(wr_reg_address) && $stable(wr_seg_data) && $stable(wr_last_write), "stalled write item changed")

endmodule

bind seven_segment_number_formatter ssnf_checker #(
  .NUM_DIGITS(NUM_DIGITS)
) u_ssnf_checker (
  .clk            (clk),
  .rst            (rst),
  .wr_valid       (display.valid),
  .wr_ready       (display.ready),
  .wr_reg_address (display.reg_address),
  .wr_seg_data    (display.seg_data),
  .wr_last_write  (display.last_write)
);
